// ----- design/dtsk_pkg.sv -----
// ----------------------------------------------------------------------------
// dtsk_pkg
// Shared types, character codes and the month length table for the
// timestamp text to sort key pipeline.
// ----------------------------------------------------------------------------
package dtsk_pkg;

    localparam int TEXT_W   = 64;
    localparam int KEY_W    = 40;
    localparam int YEAR_W   = 14;
    localparam int FIELD_W  = 7;
    localparam int NUM_DIG  = 12;
    localparam int NUM_CHAR = 16;

    localparam logic [YEAR_W-1:0] MAX_YEAR_RST = 14'd2025;

    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [KEY_W-1:0] SCALE_YEAR  = 40'd100000000;
    localparam logic [KEY_W-1:0] SCALE_MONTH = 40'd1000000;
    localparam logic [KEY_W-1:0] SCALE_DAY   = 40'd10000;
    localparam logic [KEY_W-1:0] SCALE_HOUR  = 40'd100;

    localparam logic [KEY_W-1:0] KEY_MAX = 40'd999912312359;

    // character positions that hold digits, in field order
    localparam int DIG_POS [NUM_DIG] = '{0, 1, 2, 3, 5, 6, 8, 9, 11, 12, 14, 15};

    typedef logic [3:0] digit_t;

    typedef struct packed {
        logic                      vld;
        logic                      fmt_ok;
        logic [NUM_DIG-1:0][3:0]   dig;
    } dtsk_dec_t;

    typedef struct packed {
        logic                vld;
        logic                ok;
        logic [YEAR_W-1:0]   year;
        logic [FIELD_W-1:0]  month;
        logic [FIELD_W-1:0]  day;
        logic [FIELD_W-1:0]  hour;
        logic [FIELD_W-1:0]  minute;
    } dtsk_fld_t;

    function automatic logic [4:0] month_days(input logic [3:0] month, input logic leap);
        logic [4:0] len;
        case (month)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = leap ? 5'd29 : 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

endpackage

// ----- design/datetime_text_to_sort_key_top.sv -----
// ----------------------------------------------------------------------------
// datetime_text_to_sort_key_top
// Parses a "YYYY-MM-DD HH:MM" timestamp into a validity flag and a sort key.
// ----------------------------------------------------------------------------
// Usage:
//   Drive text_low (characters 0..7) and text_high (characters 8..15) and
//   raise start for one cycle per transaction. busy is always low, so a new
//   transaction is taken at every rising edge where start is high.
//   After the accepting edge, a transaction passes through the decode, field
//   check, scaling and summing register stages, and done pulses for one cycle
//   with valid_res and sort_key (YYYYMMDDHHMM, or zero when invalid).
//   Throughput is one transaction per cycle.
//   The receiver cannot stall; each result is shown for exactly one cycle.
//   max_year is loaded through cfg_we / cfg_data; the user must do so only
//   while no transaction is in flight (not enforced); it is 2025 after reset.
//   Reset clears all stage valid bits, so no result appears after reset
//   until a new transaction is started.
// ----------------------------------------------------------------------------
module datetime_text_to_sort_key_top
    import dtsk_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [TEXT_W-1:0] text_low,
    input  logic [TEXT_W-1:0] text_high,
    input  logic              cfg_we,
    input  logic [YEAR_W-1:0] cfg_data,
    output logic              done,
    output logic              valid_res,
    output logic [KEY_W-1:0]  sort_key
);

    logic [YEAR_W-1:0] max_year_reg;
    dtsk_dec_t         dec;
    dtsk_fld_t         fld;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_year_reg <= MAX_YEAR_RST;
        end
        else if (cfg_we)
        begin
            max_year_reg <= cfg_data;
        end
    end

    dtsk_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_vld    (start && !busy),
        .text_low  (text_low),
        .text_high (text_high),
        .dec       (dec)
    );

    dtsk_fields u_fields (
        .clk      (clk),
        .rst_n    (rst_n),
        .max_year (max_year_reg),
        .dec      (dec),
        .fld      (fld)
    );

    dtsk_key u_key (
        .clk       (clk),
        .rst_n     (rst_n),
        .fld       (fld),
        .done      (done),
        .valid_res (valid_res),
        .sort_key  (sort_key)
    );

`ifndef SYNTH
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##4 done)
        else $error("accepted transaction did not complete after four cycles");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !(start && !busy) |-> ##4 !done)
        else $error("result without an accepted transaction");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !valid_res) |-> (sort_key == '0))
        else $error("invalid timestamp with nonzero key");

    a_key_range: assert property (@(posedge clk) disable iff (!rst_n)
        (done && valid_res) |-> (sort_key <= KEY_MAX))
        else $error("sort key out of range");
`endif

endmodule

// ----- design/dtsk_decode.sv -----
// ----------------------------------------------------------------------------
// dtsk_decode
// First stage: checks separators and digit characters, extracts digit values.
// ----------------------------------------------------------------------------
module dtsk_decode
    import dtsk_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_vld,
    input  logic [TEXT_W-1:0] text_low,
    input  logic [TEXT_W-1:0] text_high,
    output dtsk_dec_t         dec
);

    logic [2*TEXT_W-1:0]     text;
    logic                    vld_reg;
    logic                    fmt_ok_reg;
    logic                    fmt_ok_next;
    logic [NUM_DIG-1:0][3:0] dig_reg;
    logic [NUM_DIG-1:0][3:0] dig_next;

    assign text = {text_high, text_low};

    always_comb
    begin
        logic [7:0] c;
        fmt_ok_next = (text[8*4 +: 8] == CH_DASH) && (text[8*7 +: 8] == CH_DASH)
                   && (text[8*10 +: 8] == CH_SPACE) && (text[8*13 +: 8] == CH_COLON);
        for (int i = 0; i < NUM_DIG; i++)
        begin
            c = text[8*DIG_POS[i] +: 8];
            if (c >= CH_ZERO && c <= CH_NINE)
            begin
                dig_next[i] = 4'(c - CH_ZERO);
            end
            else
            begin
                dig_next[i] = 4'd0;
                fmt_ok_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        fmt_ok_reg <= fmt_ok_next;
        dig_reg    <= dig_next;
    end

    assign dec.vld    = vld_reg;
    assign dec.fmt_ok = fmt_ok_reg;
    assign dec.dig    = dig_reg;

endmodule

// ----- design/dtsk_fields.sv -----
// ----------------------------------------------------------------------------
// dtsk_fields
// Second stage: builds year, month, day, hour, minute and checks their ranges.
// ----------------------------------------------------------------------------
module dtsk_fields
    import dtsk_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [YEAR_W-1:0] max_year,
    input  dtsk_dec_t         dec,
    output dtsk_fld_t         fld
);

    logic               vld_reg;
    logic               ok_reg;
    logic               ok_next;
    logic [YEAR_W-1:0]  year_reg, year_next;
    logic [FIELD_W-1:0] month_reg, month_next;
    logic [FIELD_W-1:0] day_reg, day_next;
    logic [FIELD_W-1:0] hour_reg, hour_next;
    logic [FIELD_W-1:0] minute_reg, minute_next;
    logic [4:0]         max_day;
    logic               month_ok;

    function automatic logic [FIELD_W-1:0] two_dig(input digit_t hi, input digit_t lo);
        return FIELD_W'(hi) * FIELD_W'(10) + FIELD_W'(lo);
    endfunction

    always_comb
    begin
        year_next   = YEAR_W'(dec.dig[0]) * YEAR_W'(1000) + YEAR_W'(dec.dig[1]) * YEAR_W'(100)
                    + YEAR_W'(dec.dig[2]) * YEAR_W'(10) + YEAR_W'(dec.dig[3]);
        month_next  = two_dig(dec.dig[4], dec.dig[5]);
        day_next    = two_dig(dec.dig[6], dec.dig[7]);
        hour_next   = two_dig(dec.dig[8], dec.dig[9]);
        minute_next = two_dig(dec.dig[10], dec.dig[11]);

        month_ok = (month_next >= FIELD_W'(1)) && (month_next <= FIELD_W'(12));
        // only year mod 4 decides a leap year
        max_day  = month_ok ? month_days(month_next[3:0], year_next[1:0] == 2'b00) : 5'd0;

        ok_next = dec.fmt_ok && (year_next <= max_year) && month_ok
               && (day_next >= FIELD_W'(1)) && (day_next <= FIELD_W'(max_day))
               && (hour_next <= FIELD_W'(23)) && (minute_next <= FIELD_W'(59));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= dec.vld;
        end
    end

    always_ff @(posedge clk)
    begin
        ok_reg     <= ok_next;
        year_reg   <= year_next;
        month_reg  <= month_next;
        day_reg    <= day_next;
        hour_reg   <= hour_next;
        minute_reg <= minute_next;
    end

    assign fld.vld    = vld_reg;
    assign fld.ok     = ok_reg;
    assign fld.year   = year_reg;
    assign fld.month  = month_reg;
    assign fld.day    = day_reg;
    assign fld.hour   = hour_reg;
    assign fld.minute = minute_reg;

endmodule

// ----- design/dtsk_key.sv -----
// ----------------------------------------------------------------------------
// dtsk_key
// Third and fourth stages: scales the fields, then sums them into the key.
// ----------------------------------------------------------------------------
module dtsk_key
    import dtsk_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  dtsk_fld_t        fld,
    output logic             done,
    output logic             valid_res,
    output logic [KEY_W-1:0] sort_key
);

    logic             vld3_reg;
    logic             ok3_reg;
    logic [KEY_W-1:0] year_part_reg, year_part_next;
    logic [KEY_W-1:0] date_part_reg, date_part_next;
    logic [KEY_W-1:0] time_part_reg, time_part_next;
    logic             done_reg;
    logic             valid_res_reg;
    logic [KEY_W-1:0] sort_key_reg, sort_key_next;

    always_comb
    begin
        year_part_next = KEY_W'(fld.year) * SCALE_YEAR;
        date_part_next = KEY_W'(fld.month) * SCALE_MONTH + KEY_W'(fld.day) * SCALE_DAY;
        time_part_next = KEY_W'(fld.hour) * SCALE_HOUR + KEY_W'(fld.minute);
        // drop the key of an invalid timestamp
        sort_key_next  = ok3_reg ? (year_part_reg + date_part_reg + time_part_reg)
                                 : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld3_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            vld3_reg <= fld.vld;
            done_reg <= vld3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        ok3_reg       <= fld.ok;
        year_part_reg <= year_part_next;
        date_part_reg <= date_part_next;
        time_part_reg <= time_part_next;
        valid_res_reg <= ok3_reg;
        sort_key_reg  <= sort_key_next;
    end

    assign done      = done_reg;
    assign valid_res = valid_res_reg;
    assign sort_key  = sort_key_reg;

endmodule
